FILE: hdl/fcbc_pkg.sv
// Shared types and constants for the FASTQ column base counter.
// No dependencies; imported by fcbc_front, fcbc_back and the top level.
package fcbc_pkg;

  localparam logic [7:0] BASE_A   = 8'd65;
  localparam logic [7:0] BASE_T   = 8'd84;
  localparam logic [7:0] BASE_C   = 8'd67;
  localparam logic [7:0] BASE_G   = 8'd71;
  localparam logic [7:0] LINE_END = 8'd10;

  localparam logic ACT_STREAM = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  localparam logic [1:0] PHASE_HEADER   = 2'd0;
  localparam logic [1:0] PHASE_SEQUENCE = 2'd1;

  localparam int CFG_W = 9;
  localparam logic [CFG_W-1:0] LIMIT_RESET = 9'd256;

  localparam int CLASS_COUNT = 5;
  localparam int CLS_W = 3;
  localparam logic [CLS_W-1:0] CLS_A     = 3'd0;
  localparam logic [CLS_W-1:0] CLS_T     = 3'd1;
  localparam logic [CLS_W-1:0] CLS_C     = 3'd2;
  localparam logic [CLS_W-1:0] CLS_G     = 3'd3;
  localparam logic [CLS_W-1:0] CLS_OTHER = 3'd4;

  localparam int OUT_W = 32;
  localparam int RES_W = 6 * OUT_W;

  localparam int OP_DEPTH   = 4;
  localparam int OP_CNT_W   = $clog2(OP_DEPTH + 1);
  localparam int OUT_DEPTH  = 4;
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic             query;
    logic             blank;
    logic [CLS_W-1:0] cls;
  } fcbc_ctl_t;

  localparam int CTL_W = $bits(fcbc_ctl_t);

  function automatic logic [CLS_W-1:0] base_class(input logic [7:0] b);
    logic [CLS_W-1:0] c;
    unique case (b)
      BASE_A:  c = CLS_A;
      BASE_T:  c = CLS_T;
      BASE_C:  c = CLS_C;
      BASE_G:  c = CLS_G;
      default: c = CLS_OTHER;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/fcbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fcbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/fcbc_queue.sv
// Small register FIFO with occupancy count; used for the op queue and result queue.
// No dependencies.
module fcbc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           head_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int IW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [IW-1:0]    wr_ptr;
  logic [IW-1:0]    rd_ptr;

  function automatic logic [IW-1:0] bump(input logic [IW-1:0] p);
    return (p == IW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/fcbc_front.sv
// Front end: takes stream and query items, tracks line phase, column and read total,
// and issues counter ops to the op queue. Depends on fcbc_pkg.
module fcbc_front #(
  parameter int MAX_COLUMNS = 256,
  parameter int COUNT_BITS  = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic [7:0]                        in_byte,
  input  logic [7:0]                        query_column,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fcbc_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              clearing,
  input  logic [fcbc_pkg::OP_CNT_W-1:0]     op_count,
  output logic                              op_push,
  output logic [COUNT_BITS+$clog2(MAX_COLUMNS)+fcbc_pkg::CTL_W-1:0] op_data
);
  import fcbc_pkg::*;

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int POS_W = $clog2(MAX_COLUMNS + 1);

  logic [CFG_W-1:0]      column_limit;
  logic [1:0]            line_phase, line_phase_next;
  logic [POS_W-1:0]      column_position, column_position_next;
  logic [COUNT_BITS-1:0] read_total, read_total_next;

  logic [POS_W-1:0] eff_lim;
  logic             accept;
  fcbc_ctl_t        op_ctl;
  logic [COL_W-1:0] op_col;

  assign cfg_ready = 1'b1;
  assign in_stall  = clearing || (op_count == OP_CNT_W'(OP_DEPTH));
  assign accept    = in_valid && !in_stall;
  assign eff_lim   = (int'(column_limit) < MAX_COLUMNS) ? POS_W'(column_limit)
                                                        : POS_W'(MAX_COLUMNS);
  assign op_data   = {read_total, op_col, op_ctl};

  always_comb begin
    line_phase_next      = line_phase;
    column_position_next = column_position;
    read_total_next      = read_total;
    op_push              = 1'b0;
    op_ctl               = '0;
    op_col               = COL_W'(column_position);
    if (accept) begin
      if (action == ACT_QUERY) begin
        op_push      = 1'b1;
        op_ctl.query = 1'b1;
        op_ctl.blank = int'(query_column) >= MAX_COLUMNS;
        op_col       = COL_W'(query_column);
      end else if (in_byte == LINE_END) begin
        if (line_phase == PHASE_HEADER && read_total != '1) begin
          read_total_next = read_total + 1'b1;
        end
        line_phase_next      = line_phase + 1'b1;
        column_position_next = '0;
      end else if (column_position < eff_lim) begin
        op_push              = (line_phase == PHASE_SEQUENCE);
        op_ctl.cls           = base_class(in_byte);
        column_position_next = column_position + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_limit    <= LIMIT_RESET;
      line_phase      <= '0;
      column_position <= '0;
      read_total      <= '0;
    end else begin
      if (cfg_valid) begin
        column_limit <= cfg_data;
      end
      line_phase      <= line_phase_next;
      column_position <= column_position_next;
      read_total      <= read_total_next;
    end
  end

endmodule

FILE: hdl/fcbc_back.sv
// Back end: per-class counter RAMs with read-modify-write pipeline, forwarding,
// clearing pass after reset, and the result queue. Depends on fcbc_pkg, fcbc_ram, fcbc_queue.
module fcbc_back #(
  parameter int MAX_COLUMNS = 256,
  parameter int COUNT_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [COUNT_BITS+$clog2(MAX_COLUMNS)+fcbc_pkg::CTL_W-1:0] op_head,
  input  logic [fcbc_pkg::OP_CNT_W-1:0] op_count,
  output logic                          op_pop,
  output logic                          clearing,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fcbc_pkg::OUT_W-1:0]    count_a,
  output logic [fcbc_pkg::OUT_W-1:0]    count_t,
  output logic [fcbc_pkg::OUT_W-1:0]    count_c,
  output logic [fcbc_pkg::OUT_W-1:0]    count_g,
  output logic [fcbc_pkg::OUT_W-1:0]    count_other,
  output logic [fcbc_pkg::OUT_W-1:0]    reads_seen
);
  import fcbc_pkg::*;

  localparam int COL_W = $clog2(MAX_COLUMNS);

  fcbc_ctl_t             head_ctl;
  logic [COL_W-1:0]      head_col;
  logic                  issue;

  logic                  s1_valid;
  fcbc_ctl_t             s1_ctl;
  logic [COL_W-1:0]      s1_col;
  logic [COUNT_BITS-1:0] s1_total;
  logic                  s1_query;

  logic                  fwd_valid;
  logic [CLS_W-1:0]      fwd_cls;
  logic [COL_W-1:0]      fwd_col;
  logic [COUNT_BITS-1:0] fwd_data;

  logic [COL_W-1:0]      clr_addr;

  logic [COUNT_BITS-1:0] rdata [CLASS_COUNT];
  logic [COUNT_BITS-1:0] cur   [CLASS_COUNT];
  logic [OUT_W-1:0]      res   [CLASS_COUNT];
  logic [COUNT_BITS-1:0] sel, bumped;
  logic [CLASS_COUNT-1:0] we;
  logic [COL_W-1:0]      waddr;
  logic [COUNT_BITS-1:0] wdata;

  logic                  out_push, out_pop;
  logic [RES_W-1:0]      out_data, out_head;
  logic [OUT_CNT_W-1:0]  out_count;
  logic [OUT_CNT_W:0]    out_load;

  assign head_ctl = fcbc_ctl_t'(op_head[CTL_W-1:0]);
  assign head_col = op_head[CTL_W +: COL_W];

  // results in flight count against result queue room
  assign s1_query = s1_valid && s1_ctl.query;
  assign out_load = {1'b0, out_count} + (OUT_CNT_W+1)'(s1_query);
  assign issue    = !clearing && (op_count != '0) &&
                    (!head_ctl.query || (out_load < (OUT_CNT_W+1)'(OUT_DEPTH)));
  assign op_pop   = issue;

  generate
    for (genvar k = 0; k < CLASS_COUNT; k++) begin : g_cls
      fcbc_ram #(
        .WIDTH(COUNT_BITS),
        .DEPTH(MAX_COLUMNS)
      ) u_ram (
        .clk  (clk),
        .we   (we[k]),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(head_col),
        .rdata(rdata[k])
      );

      assign cur[k] = (fwd_valid && fwd_cls == CLS_W'(k) && fwd_col == s1_col)
                      ? fwd_data : rdata[k];
      assign res[k] = s1_ctl.blank ? '0 : OUT_W'(cur[k]);
      assign we[k]  = clearing ||
                      (s1_valid && !s1_ctl.query && s1_ctl.cls == CLS_W'(k));
    end
  endgenerate

  assign sel    = cur[s1_ctl.cls];
  assign bumped = (sel == '1) ? sel : sel + 1'b1;
  assign waddr  = clearing ? clr_addr : s1_col;
  assign wdata  = clearing ? '0 : bumped;

  always_ff @(posedge clk) begin
    s1_ctl   <= head_ctl;
    s1_col   <= head_col;
    s1_total <= op_head[CTL_W+COL_W +: COUNT_BITS];
    fwd_cls  <= s1_ctl.cls;
    fwd_col  <= s1_col;
    fwd_data <= bumped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      clearing  <= 1'b1;
      clr_addr  <= '0;
    end else begin
      s1_valid  <= issue;
      fwd_valid <= s1_valid && !s1_ctl.query;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == COL_W'(MAX_COLUMNS - 1)) begin
          clearing <= 1'b0;
        end
      end
    end
  end

  assign out_push = s1_query;
  assign out_data = {OUT_W'(s1_total), res[CLS_OTHER], res[CLS_G], res[CLS_C],
                     res[CLS_T], res[CLS_A]};
  assign out_valid = (out_count != '0);
  assign out_pop   = out_valid && !out_stall;

  fcbc_queue #(
    .WIDTH(RES_W),
    .DEPTH(OUT_DEPTH)
  ) u_res_q (
    .clk      (clk),
    .rst      (rst),
    .push     (out_push),
    .push_data(out_data),
    .pop      (out_pop),
    .head_data(out_head),
    .count    (out_count)
  );

  assign count_a     = out_head[0*OUT_W +: OUT_W];
  assign count_t     = out_head[1*OUT_W +: OUT_W];
  assign count_c     = out_head[2*OUT_W +: OUT_W];
  assign count_g     = out_head[3*OUT_W +: OUT_W];
  assign count_other = out_head[4*OUT_W +: OUT_W];
  assign reads_seen  = out_head[5*OUT_W +: OUT_W];

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_valid)
    else $error("op in flight during clearing pass");

  a_res_room: assert property (@(posedge clk) disable iff (rst)
    s1_query |-> (out_count < OUT_CNT_W'(OUT_DEPTH)))
    else $error("result queue overflow");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !clearing |-> $onehot0(we))
    else $error("more than one counter RAM written");

endmodule

FILE: hdl/fastq_column_base_counter.sv
// Top level of the FASTQ per-column base counter: front end, op queue, back end.
// Depends on fcbc_pkg, fcbc_front, fcbc_queue, fcbc_back.
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------------
//  in      | in_valid / in_stall    | action, in_byte, query_column
//  out     | out_valid / out_stall  | count_a/t/c/g/other, reads_seen
//  cfg     | cfg_valid / cfg_ready  | cfg_data (column_limit)
//
// One item per cycle while in_stall is low; each counter update is one RAM
// read-modify-write through stage s1, with last-write forwarding.
// With no backlog, an accepted query passes through the op queue, the s1
// register and the result queue before out_valid rises.
// After reset a clearing pass over all MAX_COLUMNS addresses zeroes the
// counter RAMs; in_stall is high meanwhile. in_stall also rises when the op
// queue is full, which happens when out_stall backs up queries.
module fastq_column_base_counter #(
  parameter int MAX_COLUMNS = 256,
  parameter int COUNT_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  in_byte,
  input  logic [7:0]  query_column,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] count_a,
  output logic [31:0] count_t,
  output logic [31:0] count_c,
  output logic [31:0] count_g,
  output logic [31:0] count_other,
  output logic [31:0] reads_seen,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data
);
  import fcbc_pkg::*;

  localparam int OP_W = COUNT_BITS + $clog2(MAX_COLUMNS) + CTL_W;

  logic                clearing;
  logic                op_push, op_pop;
  logic [OP_W-1:0]     op_data, op_head;
  logic [OP_CNT_W-1:0] op_count;

  fcbc_front #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .in_byte     (in_byte),
    .query_column(query_column),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .clearing    (clearing),
    .op_count    (op_count),
    .op_push     (op_push),
    .op_data     (op_data)
  );

  fcbc_queue #(
    .WIDTH(OP_W),
    .DEPTH(OP_DEPTH)
  ) u_op_q (
    .clk      (clk),
    .rst      (rst),
    .push     (op_push),
    .push_data(op_data),
    .pop      (op_pop),
    .head_data(op_head),
    .count    (op_count)
  );

  fcbc_back #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .op_head    (op_head),
    .op_count   (op_count),
    .op_pop     (op_pop),
    .clearing   (clearing),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .count_a    (count_a),
    .count_t    (count_t),
    .count_c    (count_c),
    .count_g    (count_g),
    .count_other(count_other),
    .reads_seen (reads_seen)
  );

endmodule

FILE: tb/fcbc_checker.sv
`timescale 1ns / 100ps
// Checker for the FASTQ column base counter: watches the item, result and config
// channels, keeps its own per-column base tallies and compares every query result.
// Depends on fcbc_pkg.
module fcbc_checker #(
  parameter int MAX_COLUMNS = 256,
  parameter int COUNT_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        action,
  input  logic [7:0]  in_byte,
  input  logic [7:0]  query_column,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] count_a,
  input  logic [31:0] count_t,
  input  logic [31:0] count_c,
  input  logic [31:0] count_g,
  input  logic [31:0] count_other,
  input  logic [31:0] reads_seen,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [8:0]  cfg_data,
  output int          mismatches,
  output int          awaiting,
  output int          answered
);
  import fcbc_pkg::*;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] t;
    logic [31:0] c;
    logic [31:0] g;
    logic [31:0] other;
    logic [31:0] reads;
  } column_report_t;

  typedef struct {
    logic [7:0]     col;
    column_report_t rep;
  } due_report_t;

  due_report_t           reports_due[$];
  logic [COUNT_BITS-1:0] tally[CLASS_COUNT][MAX_COLUMNS];
  logic [COUNT_BITS-1:0] read_total;
  logic [8:0]            col_limit;
  logic [1:0]            line_phase;
  int                    col_pos;

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic int class_of(input logic [7:0] b);
    if (b == BASE_A) return CLS_A;
    if (b == BASE_T) return CLS_T;
    if (b == BASE_C) return CLS_C;
    if (b == BASE_G) return CLS_G;
    return CLS_OTHER;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    int lim;
    lim = (int'(col_limit) < MAX_COLUMNS) ? int'(col_limit) : MAX_COLUMNS;
    if (b == LINE_END) begin
      if (line_phase == PHASE_HEADER) read_total = bump(read_total);
      line_phase = line_phase + 2'd1;
      col_pos = 0;
    end else if (col_pos < lim) begin
      if (line_phase == PHASE_SEQUENCE)
        tally[class_of(b)][col_pos] = bump(tally[class_of(b)][col_pos]);
      col_pos++;
    end
  endfunction

  function automatic column_report_t report_for(input logic [7:0] q);
    column_report_t r;
    r = '0;
    if (q < MAX_COLUMNS) begin
      r.a     = 32'(tally[CLS_A][q]);
      r.t     = 32'(tally[CLS_T][q]);
      r.c     = 32'(tally[CLS_C][q]);
      r.g     = 32'(tally[CLS_G][q]);
      r.other = 32'(tally[CLS_OTHER][q]);
    end
    r.reads = 32'(read_total);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    column_report_t seen;
    due_report_t    due;
    if (rst) begin
      for (int k = 0; k < CLASS_COUNT; k++)
        for (int c = 0; c < MAX_COLUMNS; c++)
          tally[k][c] = '0;
      read_total = '0;
      col_limit = LIMIT_RESET;
      line_phase = PHASE_HEADER;
      col_pos = 0;
      reports_due.delete();
      mismatches = 0;
      answered = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = {count_a, count_t, count_c, count_g, count_other, reads_seen};
        answered++;
        if (reports_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: A/T/C/G/other %0d/%0d/%0d/%0d/%0d reads %0d",
                     seen.a, seen.t, seen.c, seen.g, seen.other, seen.reads);
        end else begin
          due = reports_due.pop_front();
          if (seen !== due.rep) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("column %0d expected A/T/C/G/other %0d/%0d/%0d/%0d/%0d reads %0d",
                       due.col, due.rep.a, due.rep.t, due.rep.c, due.rep.g,
                       due.rep.other, due.rep.reads);
              $display("column %0d actual   A/T/C/G/other %0d/%0d/%0d/%0d/%0d reads %0d",
                       due.col, seen.a, seen.t, seen.c, seen.g, seen.other, seen.reads);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) col_limit = cfg_data;
      if (in_valid && !in_stall) begin
        if (action == ACT_QUERY) begin
          due.col = query_column;
          due.rep = report_for(query_column);
          reports_due.push_back(due);
        end else begin
          absorb_byte(in_byte);
        end
      end
    end
    awaiting = reports_due.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the FASTQ column base counter: clock, reset, FASTQ-shaped
// stimulus, limit changes and verdict. Depends on fcbc_pkg,
// fastq_column_base_counter and fcbc_checker.
module tb_top;
  import fcbc_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE      = 8;
  localparam int SHORT_LINE  = 40;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 20;

  typedef enum {LN_TEXT, LN_SEQ, LN_QUAL, LN_NOISE} line_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = ACT_STREAM;
  logic [7:0]  in_byte = '0;
  logic [7:0]  query_column = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] count_a;
  logic [31:0] count_t;
  logic [31:0] count_c;
  logic [31:0] count_g;
  logic [31:0] count_other;
  logic [31:0] reads_seen;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;

  int          mismatches;
  int          awaiting;
  int          answered;
  int          items_sent = 0;
  int          queries_sent = 0;
  int          limit_writes = 0;
  int          quiet_cycles = 0;
  logic        steady = 1'b0;
  logic [8:0]  cur_limit = LIMIT_RESET;
  logic [7:0]  bases[4] = '{BASE_A, BASE_T, BASE_C, BASE_G};
  logic [8:0]  plan[PHASES] = '{9'd0, 9'd1, 9'd511, 9'd9, 9'd256, 9'd0, 9'd255};

  always #2 clk = ~clk;

  fastq_column_base_counter DUT (.*);

  fcbc_checker watcher (.*);

  always @(posedge clk)
    out_stall <= !steady && ($urandom_range(0, 99) < 20);

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("[fastq_column_base_counter] ERROR");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  task automatic send_item(input logic act, input logic [7:0] b, input logic [7:0] q);
    while (!steady && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    in_byte <= b;
    query_column <= q;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (act == ACT_QUERY) queries_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(ACT_STREAM, b, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_query(input logic [7:0] q);
    send_item(ACT_QUERY, 8'($urandom_range(0, 255)), q);
  endtask

  // queries are sprinkled in, mostly at columns that short lines reach
  task automatic send_line(input line_kind_t kind, input int len);
    logic [7:0] b;
    int         span;
    span = (cur_limit < SHORT_LINE) ? int'(cur_limit) + 2 : SHORT_LINE;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 6)
        send_query(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, span)));
      b = 8'($urandom_range(0, 255));
      unique case (kind)
        LN_SEQ:   if ($urandom_range(0, 9) < 8) b = bases[$urandom_range(0, 3)];
        LN_QUAL:  b = 8'($urandom_range(33, 74));
        LN_TEXT:  b = 8'($urandom_range(32, 126));
        default:  ;
      endcase
      if (b == LINE_END) b = 8'd0;
      send_byte(b);
    end
    send_byte(LINE_END);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    logic [7:0] probe[8];
    int         phase_end;
    int         len;
    probe = '{BASE_A, BASE_T, BASE_C, BASE_G, 8'h00, 8'hFF, 8'd13, "N"};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty store, every base class, an empty read, far columns
    send_query(8'd0);
    send_query(8'd255);
    send_byte("@");
    send_byte(LINE_END);
    foreach (probe[i]) send_byte(probe[i]);
    send_byte(LINE_END);
    send_byte("+");
    send_byte(LINE_END);
    send_byte("I");
    send_byte("I");
    send_byte(LINE_END);
    repeat (4) send_byte(LINE_END);
    send_query(8'd0);
    send_query(8'd4);
    send_query(8'd5);
    send_query(8'd7);
    send_query(8'd255);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      cfg_valid <= 1'b1;
      cfg_data <= (p == 5) ? 9'($urandom_range(2, 200)) : plan[p];
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;
      cur_limit = cfg_data;
      limit_writes++;
      steady = (p == 2);
      if (p == 2) begin
        // sequence line longer than every column
        send_line(LN_TEXT, 2);
        send_line(LN_SEQ, 262);
        send_line(LN_TEXT, 0);
        send_line(LN_QUAL, 4);
        for (int k = 0; k < 6; k++) send_query(8'(250 + k));
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 16) : $urandom_range(0, 40);
        if ($urandom_range(0, 99) < 12) begin
          repeat (4) send_line(LN_NOISE, $urandom_range(0, 8));
        end else begin
          send_line(LN_TEXT, $urandom_range(0, 6));
          send_line(LN_SEQ, len);
          send_line(LN_TEXT, $urandom_range(0, 1));
          send_line(LN_QUAL, len);
        end
      end
    end
    steady = 1'b0;

    drain();
    $display("sent %0d items (%0d queries), checked %0d results over %0d column limits",
             items_sent, queries_sent, answered, limit_writes);
    $display("limits covered none, one, nine, all columns and above; one read overran them");
    if (mismatches == 0 && awaiting == 0)
      $display("[fastq_column_base_counter] OK");
    else
      $display("[fastq_column_base_counter] ERROR");
    $finish;
  end

endmodule
